/* rtl/gaas_pkg.sv */
// shared widths and event kind codes for the grid-aligned alarm scheduler
`timescale 1ns / 1ps

package gaas_pkg;

    localparam int TIME_W = 32;
    localparam int IVL_W  = 17;
    localparam int KIND_W = 3;
    localparam int STEP_W = $clog2(TIME_W);

    localparam logic [KIND_W-1:0] KIND_START    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POLL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MARK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SANITY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAILSAFE = 3'd5;

    typedef logic [TIME_W-1:0] epoch_t;
    typedef logic [IVL_W-1:0]  ivl_t;

endpackage

/* rtl/gaas_rem.sv */
// bit-serial restoring remainder unit: epoch modulo grid interval, one bit per cycle
`timescale 1ns / 1ps

module gaas_rem (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  gaas_pkg::epoch_t dividend,
    input  gaas_pkg::ivl_t   divisor,
    output logic            done,
    output gaas_pkg::ivl_t   remainder
);
    import gaas_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    epoch_t            dvd_reg;
    ivl_t              div_reg;
    ivl_t              rem_reg;

    logic [IVL_W:0]    trial;
    logic [IVL_W:0]    diff;
    ivl_t              rem_next;

    // shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[TIME_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = diff[IVL_W-1:0];
        end else begin
            rem_next = trial[IVL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/grid_aligned_alarm_scheduler.sv */
// top level of the grid-aligned alarm scheduler: config registers, event sequencer, result register
`timescale 1ns / 1ps

// Takes one event at a time. Poll, mark, unused kinds and events that find nothing to do
// go from idle straight to the done state and load their result into the output register
// as soon as it is free. Start, sanity and failsafe realignments and an advance that has to
// step the target first run the bit-serial remainder unit, which works out the epoch (for an
// advance, its distance past the target) modulo the interval; then the grid point is formed,
// a realignment corrects it in the adjust state, and the done state loads the result. s_ready is
// high while the sequencer is idle, also while a result waits in the output register; a
// result still waiting on m_ready holds the next event in the sequencer until it leaves.
// Configuration is written through the APB port; an interval of zero acts as one second.
module grid_aligned_alarm_scheduler (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // events
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gaas_pkg::KIND_W-1:0]  s_kind,
    input  gaas_pkg::epoch_t             s_now_epoch,
    input  logic                         s_alarm_flag,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_fire,
    output logic                         m_program_strobe,
    output logic                         m_clear_strobe,
    output gaas_pkg::epoch_t             m_target_epoch,
    output gaas_pkg::epoch_t             m_anchor_epoch
);
    import gaas_pkg::*;

    localparam logic [2:0] REG_CLOCK_PRESENT = 3'd0;
    localparam logic [2:0] REG_INTERVAL      = 3'd1;
    localparam logic [2:0] REG_MAX_AHEAD     = 3'd2;
    localparam logic [2:0] REG_SILENCE       = 3'd3;
    localparam logic [2:0] REG_FAILSAFE_ON   = 3'd4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_ADJ  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_ADVANCE  = 3'd2;
    localparam logic [2:0] ACT_SANITY   = 3'd3;
    localparam logic [2:0] ACT_FAILSAFE = 3'd4;

    // configuration registers
    logic   clock_present_reg;
    ivl_t   interval_reg;
    epoch_t max_ahead_reg;
    epoch_t silence_reg;
    logic   failsafe_on_reg;

    // scheduler state
    epoch_t target_reg;
    epoch_t anchor_reg;
    epoch_t last_fire_reg;

    logic [1:0] state_reg;
    logic [2:0] act_reg;
    epoch_t     now_reg;
    epoch_t     grid_reg;
    logic       fire_p_reg;
    logic       prog_p_reg;
    logic       clr_p_reg;

    logic       m_valid_reg;
    logic       m_fire_reg;
    logic       m_prog_reg;
    logic       m_clr_reg;
    epoch_t     m_target_reg;
    epoch_t     m_anchor_reg;

    logic       cfg_write;
    logic       accept;
    logic       live;
    logic       target_set;
    ivl_t       eff_ivl;
    logic [2:0] act_next;
    logic       fire_next;
    logic       prog_next;
    logic       clr_next;
    epoch_t     rem_dividend;
    epoch_t     ahead;
    epoch_t     gap;
    logic       rem_done;
    ivl_t       rem_val;
    ivl_t       step_up;
    logic       out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign live      = clock_present_reg;
    assign target_set = (target_reg != '0);
    assign eff_ivl   = (interval_reg == '0) ? IVL_W'(1) : interval_reg;
    assign ahead     = target_reg - s_now_epoch;
    assign gap       = s_now_epoch - last_fire_reg;
    assign step_up   = eff_ivl - rem_val;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        unique case (paddr[4:2])
            REG_CLOCK_PRESENT: prdata = {31'b0, clock_present_reg};
            REG_INTERVAL:      prdata = {{(32-IVL_W){1'b0}}, interval_reg};
            REG_MAX_AHEAD:     prdata = max_ahead_reg;
            REG_SILENCE:       prdata = silence_reg;
            REG_FAILSAFE_ON:   prdata = {31'b0, failsafe_on_reg};
            default:           prdata = '0;
        endcase
    end

    // decide at transfer what the event does and whether it needs the remainder unit
    always_comb begin
        act_next     = ACT_NONE;
        fire_next    = 1'b0;
        prog_next    = 1'b0;
        clr_next     = 1'b0;
        rem_dividend = s_now_epoch;
        case (s_kind)
            KIND_START: begin
                if (live) begin
                    act_next  = ACT_START;
                    prog_next = 1'b1;
                end
            end
            KIND_POLL: begin
                fire_next = live && target_set && (s_alarm_flag || s_now_epoch >= target_reg);
            end
            KIND_ADVANCE: begin
                if (live && target_set) begin
                    clr_next  = 1'b1;
                    prog_next = 1'b1;
                    if (target_reg <= s_now_epoch) begin
                        act_next     = ACT_ADVANCE;
                        rem_dividend = s_now_epoch - target_reg;
                    end
                end
            end
            KIND_SANITY: begin
                if (live && target_set && target_reg >= s_now_epoch && ahead > max_ahead_reg) begin
                    act_next  = ACT_SANITY;
                    prog_next = 1'b1;
                end
            end
            KIND_FAILSAFE: begin
                if (failsafe_on_reg && live && target_set && gap > silence_reg) begin
                    act_next  = ACT_FAILSAFE;
                    prog_next = 1'b1;
                    fire_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    gaas_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && (act_next != ACT_NONE)),
        .dividend  (rem_dividend),
        .divisor   (eff_ivl),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_present_reg <= 1'b0;
            interval_reg      <= IVL_W'(60);
            max_ahead_reg     <= TIME_W'(3600);
            silence_reg       <= TIME_W'(600);
            failsafe_on_reg   <= 1'b1;
            target_reg        <= '0;
            anchor_reg        <= '0;
            last_fire_reg     <= '0;
            state_reg         <= ST_IDLE;
            act_reg           <= ACT_NONE;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[4:2])
                    REG_CLOCK_PRESENT: clock_present_reg <= pwdata[0];
                    REG_INTERVAL:      interval_reg      <= pwdata[IVL_W-1:0];
                    REG_MAX_AHEAD:     max_ahead_reg     <= pwdata;
                    REG_SILENCE:       silence_reg       <= pwdata;
                    REG_FAILSAFE_ON:   failsafe_on_reg   <= pwdata[0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        act_reg <= act_next;
                        if (s_kind == KIND_MARK && failsafe_on_reg) begin
                            last_fire_reg <= s_now_epoch;
                        end
                        state_reg <= (act_next != ACT_NONE) ? ST_CALC : ST_DONE;
                    end
                end
                ST_CALC: begin
                    if (rem_done) begin
                        state_reg <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    // alignment only: a grid point that wrapped to or below now moves one more step
                    if (act_reg != ACT_ADVANCE && grid_reg <= now_reg) begin
                        target_reg <= grid_reg + {{(TIME_W-IVL_W){1'b0}}, eff_ivl};
                        if (act_reg == ACT_START || act_reg == ACT_SANITY) begin
                            anchor_reg <= grid_reg + {{(TIME_W-IVL_W){1'b0}}, eff_ivl};
                        end
                    end else begin
                        target_reg <= grid_reg;
                        if (act_reg == ACT_START || act_reg == ACT_SANITY) begin
                            anchor_reg <= grid_reg;
                        end
                    end
                    if ((act_reg == ACT_START && failsafe_on_reg) || act_reg == ACT_FAILSAFE) begin
                        last_fire_reg <= now_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg    <= s_now_epoch;
            fire_p_reg <= fire_next;
            prog_p_reg <= prog_next;
            clr_p_reg  <= clr_next;
        end
        if (state_reg == ST_CALC && rem_done) begin
            grid_reg <= now_reg + {{(TIME_W-IVL_W){1'b0}}, step_up};
        end
        if (state_reg == ST_DONE && out_free) begin
            m_fire_reg   <= fire_p_reg;
            m_prog_reg   <= prog_p_reg;
            m_clr_reg    <= clr_p_reg;
            m_target_reg <= target_reg;
            m_anchor_reg <= anchor_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fire           = m_fire_reg;
    assign m_program_strobe = m_prog_reg;
    assign m_clear_strobe   = m_clr_reg;
    assign m_target_epoch   = m_target_reg;
    assign m_anchor_epoch   = m_anchor_reg;

endmodule

/* verif/grid_aligned_alarm_scheduler_test.sv */
// self-checking testbench for the grid-aligned alarm scheduler: directed and random event streams
`timescale 1ns / 1ps

module grid_aligned_alarm_scheduler_test;
    import gaas_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

    localparam logic [4:0] ADDR_CLOCK_PRESENT = 5'd0;
    localparam logic [4:0] ADDR_INTERVAL      = 5'd4;
    localparam logic [4:0] ADDR_MAX_AHEAD     = 5'd8;
    localparam logic [4:0] ADDR_SILENCE       = 5'd12;
    localparam logic [4:0] ADDR_FAILSAFE      = 5'd16;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 18;
    localparam int BURST_ITEMS   = 100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        epoch_t            now_epoch;
        logic              alarm_flag;
    } alarm_event_t;

    typedef struct packed {
        logic   fire;
        logic   program_strobe;
        logic   clear_strobe;
        epoch_t target_epoch;
        epoch_t anchor_epoch;
    } sched_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    epoch_t            s_now_epoch = '0;
    logic              s_alarm_flag = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_fire;
    logic              m_program_strobe;
    logic              m_clear_strobe;
    epoch_t            m_target_epoch;
    epoch_t            m_anchor_epoch;

    // predictor copy of the registers and the schedule state
    logic       cfg_clock_present = 1'b0;
    ivl_t       cfg_interval = 17'd60;
    epoch_t     cfg_max_ahead = 32'd3600;
    epoch_t     cfg_silence = 32'd600;
    logic       cfg_failsafe = 1'b1;
    epoch_t     sched_target = '0;
    epoch_t     sched_anchor = '0;
    epoch_t     sched_last_fire = '0;

    alarm_event_t  pending_events[$];
    sched_result_t due_results[$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    grid_aligned_alarm_scheduler u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_now_epoch      (s_now_epoch),
        .s_alarm_flag     (s_alarm_flag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fire           (m_fire),
        .m_program_strobe (m_program_strobe),
        .m_clear_strobe   (m_clear_strobe),
        .m_target_epoch   (m_target_epoch),
        .m_anchor_epoch   (m_anchor_epoch)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_aligned_alarm_scheduler regression: fail");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    function automatic epoch_t next_grid(input epoch_t now);
        epoch_t step;
        epoch_t g;
        step = (cfg_interval == '0) ? 32'd1 : 32'(cfg_interval);
        g = now - (now % step) + step;
        if (g <= now)
            g = g + step;
        return g;
    endfunction

    function automatic sched_result_t schedule_event(input logic [KIND_W-1:0] kind,
                                                     input epoch_t now, input logic flag);
        sched_result_t res;
        logic [63:0]   step;
        logic [63:0]   k;
        logic [63:0]   sum;
        epoch_t        gap;
        res = '0;
        case (kind)
            KIND_START: begin
                if (cfg_clock_present) begin
                    sched_target = next_grid(now);
                    sched_anchor = sched_target;
                    res.program_strobe = 1'b1;
                    if (cfg_failsafe)
                        sched_last_fire = now;
                end
            end
            KIND_POLL: begin
                if (cfg_clock_present && sched_target != '0)
                    res.fire = flag || (now >= sched_target);
            end
            KIND_ADVANCE: begin
                if (cfg_clock_present && sched_target != '0) begin
                    res.clear_strobe = 1'b1;
                    if (sched_target <= now) begin
                        // smallest step count that lands strictly past now, then wrap
                        step = (cfg_interval == '0) ? 64'd1 : 64'(cfg_interval);
                        k = (64'(now) - 64'(sched_target)) / step + 64'd1;
                        sum = 64'(sched_target) + k * step;
                        sched_target = sum[31:0];
                    end
                    res.program_strobe = 1'b1;
                end
            end
            KIND_MARK: begin
                if (cfg_failsafe)
                    sched_last_fire = now;
            end
            KIND_SANITY: begin
                if (cfg_clock_present && sched_target != '0 && sched_target >= now) begin
                    if ((sched_target - now) > cfg_max_ahead) begin
                        sched_target = next_grid(now);
                        sched_anchor = sched_target;
                        res.program_strobe = 1'b1;
                    end
                end
            end
            KIND_FAILSAFE: begin
                if (cfg_failsafe && cfg_clock_present && sched_target != '0) begin
                    gap = now - sched_last_fire;
                    // anchor stays where it was
                    if (gap > cfg_silence) begin
                        sched_target = next_grid(now);
                        sched_last_fire = now;
                        res.program_strobe = 1'b1;
                        res.fire = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.target_epoch = sched_target;
        res.anchor_epoch = sched_anchor;
        return res;
    endfunction

    // event driver
    always @(posedge aclk) begin : drive_events
        alarm_event_t ev;
        logic         holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready)
                due_results.push_back(schedule_event(s_kind, s_now_epoch, s_alarm_flag));
            if (!holding) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = pending_events.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= ev.kind;
                    s_now_epoch <= ev.now_epoch;
                    s_alarm_flag <= ev.alarm_flag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : watch_results
        sched_result_t got;
        sched_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_fire, m_program_strobe, m_clear_strobe, m_target_epoch,
                        m_anchor_epoch};
                if (due_results.size() == 0) begin
                    note_mismatch($sformatf({"unexpected result transfer: fire=%0b ",
                        "prog=%0b clr=%0b target=%h anchor=%h"},
                        got.fire, got.program_strobe, got.clear_strobe, got.target_epoch,
                        got.anchor_epoch));
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf({"result mismatch: expected fire=%0b prog=%0b ",
                            "clr=%0b target=%h anchor=%h, got fire=%0b prog=%0b clr=%0b ",
                            "target=%h anchor=%h"},
                            want.fire, want.program_strobe, want.clear_strobe,
                            want.target_epoch, want.anchor_epoch, got.fire,
                            got.program_strobe, got.clear_strobe, got.target_epoch,
                            got.anchor_epoch));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // apb write followed by a read-back of the same register
    task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
        logic [31:0] mask;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        case (addr)
            ADDR_CLOCK_PRESENT: begin mask = 32'h1;     cfg_clock_present = data[0]; end
            ADDR_INTERVAL:      begin mask = 32'h1FFFF; cfg_interval = data[16:0];   end
            ADDR_MAX_AHEAD:     begin mask = '1;        cfg_max_ahead = data;        end
            ADDR_SILENCE:       begin mask = '1;        cfg_silence = data;          end
            default:            begin mask = 32'h1;     cfg_failsafe = data[0];      end
        endcase
        if ((prdata & mask) !== (data & mask))
            note_mismatch($sformatf("register read-back at %h: expected %h, got %h",
                addr, data & mask, prdata & mask));
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // unused upper bits of the narrow registers get random junk
    task automatic set_config(input logic cp, input ivl_t iv, input epoch_t ahead,
                              input epoch_t silence, input logic fs);
        reg_write(ADDR_CLOCK_PRESENT, (32'($urandom) & ~32'h1) | 32'(cp));
        reg_write(ADDR_INTERVAL, (32'($urandom) & ~32'h1FFFF) | 32'(iv));
        reg_write(ADDR_MAX_AHEAD, ahead);
        reg_write(ADDR_SILENCE, silence);
        reg_write(ADDR_FAILSAFE, (32'($urandom) & ~32'h1) | 32'(fs));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || due_results.size() != 0);
    endtask

    task automatic push_event(input logic [KIND_W-1:0] kind, input epoch_t now,
                              input logic flag);
        pending_events.push_back('{kind, now, flag});
    endtask

    function automatic epoch_t pick_limit();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 32'($urandom_range(0, 10));
            2:       return 32'($urandom_range(0, 300));
            3:       return 32'd3600;
            4:       return '1;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic epoch_t pick_origin(input int unsigned span);
        case ($urandom_range(3))
            0:       return 32'hFFFF_FFFF - 32'($urandom_range(0, span));
            1:       return 32'($urandom_range(0, span));
            default: return 32'($urandom);
        endcase
    endfunction

    // mostly a walk of plausible event timestamps from a start, with some noise mixed in
    task automatic queue_random_burst(input int count);
        epoch_t      walk;
        int unsigned span;
        int unsigned pick;
        logic        flag;
        span = (cfg_interval == '0) ? 2 : 2 * int'(cfg_interval);
        walk = pick_origin(span);
        push_event(KIND_START, walk, 1'b0);
        for (int i = 1; i < count; i++) begin
            pick = $urandom_range(99);
            flag = ($urandom_range(9) < 3);
            if (pick < 8) begin
                push_event(KIND_W'($urandom_range(7)), 32'($urandom), 1'($urandom));
            end else if (pick < 12) begin
                walk = pick_origin(span);
                push_event(KIND_START, walk, flag);
            end else begin
                case ($urandom_range(9))
                    0:       walk = walk + 32'($urandom_range(0, 200000));
                    1:       walk = walk - 32'($urandom_range(0, span));
                    default: walk = walk + 32'($urandom_range(0, span));
                endcase
                pick = $urandom_range(99);
                if (pick < 30)      push_event(KIND_POLL, walk, flag);
                else if (pick < 50) push_event(KIND_ADVANCE, walk, flag);
                else if (pick < 65) push_event(KIND_MARK, walk, flag);
                else if (pick < 80) push_event(KIND_SANITY, walk, flag);
                else if (pick < 95) push_event(KIND_FAILSAFE, walk, flag);
                else                push_event(KIND_START, walk, flag);
            end
        end
    endtask

    initial begin : run_sequence
        ivl_t iv_pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: clock absent, mark still tracked
        push_event(KIND_START, 32'd100, 1'b1);
        push_event(KIND_MARK, 32'd500, 1'b0);
        push_event(KIND_UNUSED_7, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        set_config(1'b1, 17'd60, 32'd3600, 32'd600, 1'b1);
        push_event(KIND_START, 32'd0, 1'b0);
        push_event(KIND_POLL, 32'd59, 1'b0);
        push_event(KIND_POLL, 32'd60, 1'b0);
        push_event(KIND_POLL, 32'd10, 1'b1);
        push_event(KIND_ADVANCE, 32'd30, 1'b0);
        push_event(KIND_ADVANCE, 32'd1000, 1'b0);
        push_event(KIND_MARK, 32'd1000, 1'b0);
        push_event(KIND_FAILSAFE, 32'd1500, 1'b0);
        push_event(KIND_FAILSAFE, 32'd1700, 1'b0);
        push_event(KIND_SANITY, 32'd5000, 1'b0);
        // grid point wraps past zero
        push_event(KIND_START, 32'hFFFF_FFFF, 1'b0);
        push_event(KIND_ADVANCE, 32'hFFFF_FFFF, 1'b0);
        push_event(KIND_UNUSED_6, 32'd77, 1'b1);
        wait_drained();

        // zero interval acts as one second; advance wraps the target to unscheduled
        set_config(1'b1, 17'd0, 32'd0, 32'd0, 1'b0);
        push_event(KIND_START, 32'd100, 1'b0);
        push_event(KIND_SANITY, 32'd99, 1'b0);
        push_event(KIND_MARK, 32'd5, 1'b0);
        push_event(KIND_FAILSAFE, 32'd50, 1'b0);
        push_event(KIND_ADVANCE, 32'hFFFF_FFFF, 1'b0);
        push_event(KIND_POLL, 32'd7, 1'b1);
        wait_drained();

        set_config(1'b1, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_event(KIND_START, 32'hFFFF_FFF0, 1'b0);
        push_event(KIND_SANITY, 32'd0, 1'b0);
        push_event(KIND_FAILSAFE, 32'd0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(7))
                0:       iv_pick = 17'd0;
                1:       iv_pick = 17'd1;
                2:       iv_pick = 17'($urandom_range(2, 10));
                3:       iv_pick = 17'd60;
                4:       iv_pick = 17'd86400;
                5:       iv_pick = 17'h1FFFF;
                default: iv_pick = 17'($urandom_range(1, 131071));
            endcase
            set_config($urandom_range(9) != 0, iv_pick, pick_limit(), pick_limit(),
                       $urandom_range(4) != 0);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            queue_random_burst(BURST_ITEMS);
            wait_drained();
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("grid_aligned_alarm_scheduler regression: pass");
        end else begin
            $display("grid_aligned_alarm_scheduler regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/gaas_pkg.sv
rtl/gaas_rem.sv
rtl/grid_aligned_alarm_scheduler.sv
verif/grid_aligned_alarm_scheduler_test.sv
